>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the range reducer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define URR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Implication checked on every clock edge outside reset.
`define URR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/urr_pkg.sv
// ----------------------------------------------------------------------------
// urr_pkg
// Types and constants shared by the unbiased range reducer modules.
// ----------------------------------------------------------------------------
package urr_pkg;

    localparam int RandomBitsDefault = 64;
    localparam int WordW  = 64;
    localparam int BoundW = 32;
    localparam int DiamW  = BoundW + 1;
    localparam int QDepth = 4;

    // item classes decided by the front end
    localparam logic [2:0] K_FIXED   = 3'd0;
    localparam logic [2:0] K_INVALID = 3'd1;
    localparam logic [2:0] K_RETRY   = 3'd2;
    localparam logic [2:0] K_POS     = 3'd3;
    localparam logic [2:0] K_NEG     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RETRY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [2:0]        kind;
        logic [BoundW-1:0] span;   // diameter - 1
        logic [BoundW-1:0] base;   // low bound, or the fixed value
        logic [WordW-1:0]  word;
    } t_item;

endpackage

>>> hw/rtl/urr_front.sv
// ----------------------------------------------------------------------------
// urr_front
// Accepts commands, classifies the bounds and registers one item for the queue.
// ----------------------------------------------------------------------------
module urr_front #(
    parameter int RANDOM_BITS = urr_pkg::RandomBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_range_low,
    input  logic [31:0]         i_range_high,
    input  logic [63:0]         i_random_word,
    input  logic                i_q_full,
    output logic                o_push,
    output urr_pkg::t_item      o_item
);
    import urr_pkg::*;

    localparam logic [WordW-1:0] Umax = {WordW{1'b1}} >> (WordW - RANDOM_BITS);

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  take;
    logic  lo_neg, hi_neg, over;

    assign busy   = r_valid && i_q_full;
    assign take   = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_item = r_item;

    assign lo_neg = i_range_low[31];
    assign hi_neg = i_range_high[31];
    assign over   = i_random_word > Umax;

    always_comb begin
        n_item.word = i_random_word;
        n_item.span = '0;
        n_item.base = '0;
        if (lo_neg) begin
            n_item.kind = K_INVALID;
        end else if (i_range_low == i_range_high) begin
            n_item.kind = K_FIXED;
            n_item.base = i_range_high;
        end else if (i_range_low == '0 && hi_neg) begin
            n_item.kind = over ? K_RETRY : K_NEG;
            n_item.span = 32'd0 - i_range_high;   // 2^31 falls out for the min bound
        end else if (hi_neg || i_range_low > i_range_high) begin
            n_item.kind = K_INVALID;
        end else begin
            n_item.kind = over ? K_RETRY : K_POS;
            n_item.span = i_range_high - i_range_low;
            n_item.base = i_range_low;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/urr_queue.sv
// ----------------------------------------------------------------------------
// urr_queue
// Short FIFO between front end and back end, registered read data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  urr_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output urr_pkg::t_item o_item
);
    import urr_pkg::*;

    localparam int AW = $clog2(QDepth);

    t_item          r_mem [QDepth];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt, n_cnt;
    logic           r_valid;
    t_item          r_out;
    logic           pop;

    assign o_full  = r_cnt == (AW+1)'(QDepth);
    assign pop     = r_cnt != '0;
    assign o_valid = r_valid;
    assign o_item  = r_out;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt   <= n_cnt;
            r_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (pop) begin
            r_out <= r_mem[r_rd];
        end
    end

    `URR_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `URR_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= (AW+1)'(QDepth), "queue count out of range")

endmodule

>>> hw/rtl/urr_div.sv
// ----------------------------------------------------------------------------
// urr_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module urr_div #(
    parameter int W  = 64,
    parameter int DW = 33,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quot,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_v   [W];
    logic [DW-1:0] r_rem [W];
    logic [W-1:0]  r_q   [W];
    logic [W-1:0]  r_n   [W];
    logic [DW-1:0] r_d   [W];
    logic [SW-1:0] r_s   [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem, p_d;
        logic [W-1:0]  p_q, p_n;
        logic [SW-1:0] p_s;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [W-1:0]  n_q;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = '0;
            assign p_q   = '0;
            assign p_n   = i_dividend;
            assign p_d   = i_divisor;
            assign p_s   = i_side;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_q   = r_q[k-1];
            assign p_n   = r_n[k-1];
            assign p_d   = r_d[k-1];
            assign p_s   = r_s[k-1];
        end

        always_comb begin
            trial = {p_rem, p_n[W-1]};
            ge    = trial >= {1'b0, p_d};
            n_rem = ge ? DW'(trial - {1'b0, p_d}) : trial[DW-1:0];
            n_q   = {p_q[W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
            r_rem[k] <= n_rem;
            r_q[k]   <= n_q;
            r_n[k]   <= {p_n[W-2:0], 1'b0};
            r_d[k]   <= p_d;
            r_s[k]   <= p_s;
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_q[W-1];
    assign o_rem   = r_rem[W-1];
    assign o_side  = r_s[W-1];

endmodule

>>> hw/rtl/urr_back.sv
// ----------------------------------------------------------------------------
// urr_back
// Computes buckets and remainder, divides the word, checks rejection, outputs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urr_back #(
    parameter int RANDOM_BITS = urr_pkg::RandomBitsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  urr_pkg::t_item i_item,
    output logic           o_valid,
    output logic [31:0]    o_value,
    output logic [1:0]     o_status
);
    import urr_pkg::*;

    localparam logic [WordW-1:0] Umax = {WordW{1'b1}} >> (WordW - RANDOM_BITS);
    localparam int S1W = 3 + BoundW + WordW;
    localparam int S2W = S1W + DiamW;

    logic [S1W-1:0]   side1_in, side1_out;
    logic [S2W-1:0]   side2_out;
    logic             v1, v2;
    logic [WordW-1:0] buckets, quot2;
    logic [DiamW-1:0] rem1;
    logic [WordW-1:0] rem2_unused;

    logic [2:0]        kind;
    logic [BoundW-1:0] base;
    logic [WordW-1:0]  word;
    logic [DiamW-1:0]  rem1_d;
    logic              reject;
    logic [BoundW-1:0] drawn;

    logic        r_valid;
    logic [31:0] r_value, n_value;
    logic [1:0]  r_status, n_status;

    assign side1_in = {i_item.kind, i_item.base, i_item.word};

    // buckets = Umax / diameter; remainder gives limit = Umax - rem
    urr_div #(.W(WordW), .DW(DiamW), .SW(S1W)) u_div_buckets (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_dividend (Umax),
        .i_divisor  ({1'b0, i_item.span} + DiamW'(1)),
        .i_side     (side1_in),
        .o_valid    (v1),
        .o_quot     (buckets),
        .o_rem      (rem1),
        .o_side     (side1_out)
    );

    urr_div #(.W(WordW), .DW(WordW), .SW(S2W)) u_div_draw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (v1),
        .i_dividend (side1_out[WordW-1:0]),
        .i_divisor  (buckets),
        .i_side     ({side1_out, rem1}),
        .o_valid    (v2),
        .o_quot     (quot2),
        .o_rem      (rem2_unused),
        .o_side     (side2_out)
    );

    assign {kind, base, word, rem1_d} = side2_out;
    assign reject = word >= (Umax - WordW'(rem1_d)) || (rem2_unused == '1 && 1'b0);
    assign drawn  = quot2[BoundW-1:0];

    always_comb begin
        n_value  = '0;
        n_status = ST_OK;
        case (kind)
            K_FIXED: begin
                n_value = base;
            end
            K_RETRY: begin
                n_status = ST_RETRY;
            end
            K_POS: begin
                if (reject) begin
                    n_status = ST_RETRY;
                end else begin
                    n_value = drawn + base;
                end
            end
            K_NEG: begin
                if (reject) begin
                    n_status = ST_RETRY;
                end else begin
                    n_value = 32'd0 - drawn;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= v2;
        end
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    `URR_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, r_valid, r_status != 2'd3,
        "undefined status code")
    `URR_ASSERT_IMPL(a_flow, i_clk, i_rst_n, v2, ##1 r_valid, "result lost at output")
    `URR_ASSERT_IMPL(a_zero_on_fail, i_clk, i_rst_n, r_valid && r_status != ST_OK,
        r_value == '0, "failed result carries nonzero value")

endmodule

>>> hw/rtl/unbiased_range_reducer.sv
// ----------------------------------------------------------------------------
// unbiased_range_reducer
// Uniform integer in [low, high] from one random word, by rejection sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_range_low, i_range_high, i_random_word and raise
//   start; the command transfers on a clock edge where start is high and busy
//   is low. busy rises only when the front register is occupied and the
//   queue is full, which does not happen in steady flow: one command per cycle.
//   Result channel: o_valid strobes for one cycle with o_value and o_status
//   (0 valid, 1 word rejected - send a new word, 2 bad bounds). Results come
//   back in command order and cannot be held off.
//   Path: a command passes the front register, the queue, the two
//   bit-per-stage pipelined dividers (buckets, then word / buckets) and the
//   output register before o_valid. Every stage advances each cycle, so
//   throughput is one item per cycle.
//   Reset (i_rst_n low, synchronous) empties the queue and drops all items
//   in flight; no result is produced for them.
// ----------------------------------------------------------------------------
module unbiased_range_reducer #(
    parameter int RANDOM_BITS = urr_pkg::RandomBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    input  logic [63:0] i_random_word,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    import urr_pkg::*;

    logic  q_full, push, q_valid;
    t_item f_item, q_item;

    urr_front #(.RANDOM_BITS(RANDOM_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_random_word (i_random_word),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (f_item)
    );

    urr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    urr_back #(.RANDOM_BITS(RANDOM_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_valid  (o_valid),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule
